### design/bmhq_pkg.sv
// Package for the binary min-heap queue core: operation and status codes,
// sequencer states and default sizes. No dependencies.
package bmhq_pkg;

  localparam int HeapDepthDef  = 64;
  localparam int ValueWidthDef = 16;
  localparam int CapW          = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;
  localparam int MinCapacity   = 10;
  localparam int EmptyMark     = -32767;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_RM_LD,
    S_RM_CHK,
    S_RM_CMP,
    S_RESP
  } state_e;

endpackage

### design/bmhq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Standalone, no package dependency.
module bmhq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### design/binary_min_heap_queue_core.sv
// Binary min-heap priority queue core: heap RAM plus a level-walking sequencer.
// Depends on bmhq_pkg and bmhq_ram.
//
// Usage:
//   Slave stream: s_axis_tuser carries the operation (insert, remove minimum,
//   clear, no-op), s_axis_tdata carries the signed value for an insert.
//   Master stream: one result transaction per accepted operation, with the
//   status in m_axis_tuser and removed value, current minimum, count, empty
//   and full flags in m_axis_tdata.
//   cfg_we_i/cfg_wdata_i write the capacity (clamped to 10..HEAP_DEPTH).
// Timing:
//   One operation at a time; s_axis_tready is high only while idle.
//   Clear, no-op and rejected operations go from idle straight to S_RESP.
//   Insert walks up in S_INS_CHK and S_INS_CMP; remove loads the last entry in
//   S_RM_LD, then sinks it in S_RM_CHK and S_RM_CMP. The heap RAM walk handles
//   one tree level per cycle through one write and two read ports.
// Reset clears the count and sets capacity to 64; heap RAM is not cleared.
// A stalled receiver holds the result in the output register; the core
// finishes the current operation and waits before loading the next result.
module binary_min_heap_queue_core #(
  parameter int HEAP_DEPTH  = bmhq_pkg::HeapDepthDef,
  parameter int VALUE_WIDTH = bmhq_pkg::ValueWidthDef,
  localparam int CntW  = $clog2(HEAP_DEPTH + 1),
  localparam int InDw  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int OutFw = 2 * VALUE_WIDTH + CntW + 2,
  localparam int OutDw = ((OutFw + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bmhq_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [InDw-1:0]           s_axis_tdata,  // value
  input  logic [1:0]                s_axis_tuser,  // operation
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // removed, current_min, count, is_empty, is_full
  output logic [OutDw-1:0]          m_axis_tdata,
  output logic [1:0]                m_axis_tuser   // status
);

  localparam int Pw = CntW + 1;
  localparam int Ew = (CntW > bmhq_pkg::CapW) ? CntW : bmhq_pkg::CapW;
  localparam logic [VALUE_WIDTH-1:0] EmptyV = VALUE_WIDTH'(bmhq_pkg::EmptyMark);
  localparam logic [CntW-1:0] Root = CntW'(1);

  bmhq_pkg::state_e  state_q, state_d;
  bmhq_pkg::status_e status_q, status_d;
  bmhq_pkg::op_e     op;

  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          pos_q, pos_d;
  logic [bmhq_pkg::CapW-1:0] cap_q;
  logic [VALUE_WIDTH-1:0]   x_q, x_d;
  logic [VALUE_WIDTH-1:0]   root_q, root_d;
  logic [VALUE_WIDTH-1:0]   removed_q, removed_d;
  logic                     out_valid_q;
  logic [OutDw-1:0]         out_data_q;
  logic [1:0]               out_user_q;
  logic                     out_load;

  logic                     ram_we;
  logic [CntW-1:0]          ram_waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0]   ram_wdata, rd_a, rd_b;

  logic [Ew-1:0]            cap_ext, cap_eff;
  logic                     is_full, is_empty;
  logic [Pw-1:0]            pos2, kid2;
  logic                     has_kid, take_r;
  logic [CntW-1:0]          kid_l, kid_r, kid;
  logic [VALUE_WIDTH-1:0]   kval, cur_min;

  bmhq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (HEAP_DEPTH + 1)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  // effective capacity, clamped to the legal range
  always_comb begin
    cap_ext = Ew'(cap_q);
    if (cap_ext < Ew'(bmhq_pkg::MinCapacity)) begin
      cap_eff = Ew'(bmhq_pkg::MinCapacity);
    end else if (cap_ext > Ew'(HEAP_DEPTH)) begin
      cap_eff = Ew'(HEAP_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign is_full  = Ew'(count_q) >= cap_eff;
  assign is_empty = count_q == '0;
  assign cur_min  = is_empty ? EmptyV : root_q;

  // child addresses of the current slot (1-based heap)
  assign pos2    = Pw'(pos_q) << 1;
  assign has_kid = pos2 <= Pw'(count_q);
  assign kid_l   = pos2[CntW-1:0];
  assign kid_r   = CntW'(pos2 + Pw'(1));
  assign take_r  = (kid_l != count_q) && ($signed(rd_b) < $signed(rd_a));
  assign kid     = take_r ? kid_r : kid_l;
  assign kval    = take_r ? rd_b : rd_a;
  assign kid2    = Pw'(kid) << 1;

  assign op = bmhq_pkg::op_e'(s_axis_tuser);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    x_d       = x_q;
    removed_d = removed_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = x_q;
    raddr_a   = '0;
    raddr_b   = '0;
    out_load  = 1'b0;

    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          removed_d = '0;
          status_d  = bmhq_pkg::STAT_OK;
          state_d   = bmhq_pkg::S_RESP;
          unique case (op)
            bmhq_pkg::OP_INSERT: begin
              if (is_full) begin
                status_d = bmhq_pkg::STAT_FULL;
              end else begin
                x_d     = s_axis_tdata[VALUE_WIDTH-1:0];
                pos_d   = count_q + CntW'(1);
                count_d = count_q + CntW'(1);
                state_d = bmhq_pkg::S_INS_CHK;
              end
            end
            bmhq_pkg::OP_REMOVE: begin
              if (is_empty) begin
                status_d  = bmhq_pkg::STAT_EMPTY;
                removed_d = EmptyV;
              end else begin
                removed_d = root_q;
                raddr_a   = count_q;  // fetch last entry
                count_d   = count_q - CntW'(1);
                state_d   = bmhq_pkg::S_RM_LD;
              end
            end
            bmhq_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      bmhq_pkg::S_INS_CHK: begin
        if (pos_q == Root) begin
          ram_we  = 1'b1;
          state_d = bmhq_pkg::S_RESP;
        end else begin
          raddr_a = pos_q >> 1;
          state_d = bmhq_pkg::S_INS_CMP;
        end
      end

      bmhq_pkg::S_INS_CMP: begin
        ram_we = 1'b1;
        if ($signed(x_q) < $signed(rd_a)) begin
          // parent moves down, keep walking up; next parent read overlaps
          ram_wdata = rd_a;
          pos_d     = pos_q >> 1;
          if ((pos_q >> 1) > Root) begin
            raddr_a = pos_q >> 2;
          end else begin
            state_d = bmhq_pkg::S_INS_CHK;
          end
        end else begin
          state_d = bmhq_pkg::S_RESP;
        end
      end

      bmhq_pkg::S_RM_LD: begin
        x_d     = rd_a;
        pos_d   = Root;
        state_d = bmhq_pkg::S_RM_CHK;
      end

      bmhq_pkg::S_RM_CHK: begin
        if (has_kid) begin
          raddr_a = kid_l;
          raddr_b = kid_r;
          state_d = bmhq_pkg::S_RM_CMP;
        end else begin
          ram_we  = 1'b1;
          state_d = bmhq_pkg::S_RESP;
        end
      end

      bmhq_pkg::S_RM_CMP: begin
        ram_we = 1'b1;
        if ($signed(kval) < $signed(x_q)) begin
          ram_wdata = kval;
          pos_d     = kid;
          if (kid2 <= Pw'(count_q)) begin
            raddr_a = kid2[CntW-1:0];
            raddr_b = CntW'(kid2 + Pw'(1));
          end else begin
            state_d = bmhq_pkg::S_RM_CHK;
          end
        end else begin
          state_d = bmhq_pkg::S_RESP;
        end
      end

      bmhq_pkg::S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = bmhq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // shadow copy of slot 1 for the current minimum
  assign root_d = (ram_we && ram_waddr == Root) ? ram_wdata : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmhq_pkg::S_IDLE;
      count_q     <= '0;
      cap_q       <= bmhq_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    x_q       <= x_d;
    root_q    <= root_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    if (out_load) begin
      out_data_q <= OutDw'({is_full, is_empty, count_q, cur_min, removed_q});
      out_user_q <= status_q;
    end
  end

  assign s_axis_tready = state_q == bmhq_pkg::S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### design/bmhq_checker.sv
// Port-level checks for binary_min_heap_queue_core, attached by bind.
// Depends on bmhq_pkg.
module bmhq_checker #(
  parameter int HEAP_DEPTH  = bmhq_pkg::HeapDepthDef,
  parameter int VALUE_WIDTH = bmhq_pkg::ValueWidthDef,
  localparam int CntW  = $clog2(HEAP_DEPTH + 1),
  localparam int OutFw = 2 * VALUE_WIDTH + CntW + 2,
  localparam int OutDw = ((OutFw + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutDw-1:0] m_axis_tdata,
  input logic [1:0]       m_axis_tuser
);

  localparam int CntLo    = 2 * VALUE_WIDTH;
  localparam int EmptyBit = CntLo + CntW;
  localparam int FullBit  = EmptyBit + 1;
  localparam logic [VALUE_WIDTH-1:0] EmptyV = VALUE_WIDTH'(bmhq_pkg::EmptyMark);

  logic [VALUE_WIDTH-1:0] removed;
  logic [CntW-1:0]        count;

  assign removed = m_axis_tdata[VALUE_WIDTH-1:0];
  assign count   = m_axis_tdata[EmptyBit-1:CntLo];

  // a rejected insert is only reported against a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'(bmhq_pkg::STAT_FULL) |-> m_axis_tdata[FullBit])
    else $error("full status without full flag");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'(bmhq_pkg::STAT_EMPTY)
      |-> m_axis_tdata[EmptyBit] && removed == EmptyV)
    else $error("empty status with wrong flag or removed value");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[EmptyBit] == (count == '0))
    else $error("empty flag disagrees with count");

  // one operation at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accepted transaction");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind binary_min_heap_queue_core bmhq_checker #(
  .HEAP_DEPTH  (HEAP_DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_bmhq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
